// ----- design/roman_numeral_encoder_top_macros.svh -----
// Assertion helpers used by the encoder back end.
`ifndef ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define RNE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define RNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rne_pkg.sv -----
`timescale 1ns / 1ps

package rne_pkg;

   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned SYMBOL_W = 7;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned NUM_POS  = 4;

   localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3999;

   // reciprocal constants: floor(x * K >> S) == x / N over the ranges used
   localparam logic [12:0] RECIP_THOUSAND = 13'd4195;  // >> 22, x < 4096
   localparam logic [5:0]  RECIP_HUNDRED  = 6'd41;     // >> 12, x < 1024
   localparam logic [6:0]  RECIP_TEN      = 7'd103;    // >> 10, x < 128

   localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
   localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

   // indexed by decimal position: ones, tens, hundreds, thousands
   localparam logic [SYMBOL_W-1:0] UNIT_SYM [NUM_POS] = '{SYM_I, SYM_X, SYM_C, SYM_M};
   localparam logic [SYMBOL_W-1:0] FIVE_SYM [NUM_POS] = '{SYM_V, SYM_L, SYM_D, SYM_NONE};
   localparam logic [SYMBOL_W-1:0] TEN_SYM  [NUM_POS] = '{SYM_X, SYM_C, SYM_M, SYM_NONE};

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_OVER = 2'd2
   } rne_status_type;

   typedef logic [1:0]         rne_pos_type;
   typedef logic [DIGIT_W-1:0] rne_digit_type;

   // one classified item as held in the queue
   typedef struct packed {
      rne_status_type                  status;
      rne_pos_type                     start;   // highest nonzero digit
      logic [NUM_POS-1:0][DIGIT_W-1:0] digits;
   } rne_entry_type;

   // number of symbols a decimal digit expands to
   function automatic logic [2:0] digit_len(input rne_digit_type d);
      logic [2:0] n;
      case (d)
         4'd1, 4'd5:        n = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:              n = 3'd2;
         4'd3, 4'd7:        n = 3'd3;
         4'd8:              n = 3'd4;
         default:           n = 3'd0;
      endcase
      return n;
   endfunction

   // symbol number 'step' of digit d at decimal position pos
   function automatic logic [SYMBOL_W-1:0] digit_symbol(input rne_digit_type d,
                                                        input rne_pos_type   pos,
                                                        input logic [1:0]    step);
      logic [SYMBOL_W-1:0] s;
      case (d) inside
         [4'd1:4'd3]: s = UNIT_SYM[pos];
         4'd4:        s = (step == 2'd0) ? UNIT_SYM[pos] : FIVE_SYM[pos];
         [4'd5:4'd8]: s = (step == 2'd0) ? FIVE_SYM[pos] : UNIT_SYM[pos];
         4'd9:        s = (step == 2'd0) ? UNIT_SYM[pos] : TEN_SYM[pos];
         default:     s = SYM_NONE;
      endcase
      return s;
   endfunction

endpackage

// ----- design/rne_ifs.sv -----
`timescale 1ns / 1ps

interface rne_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rne_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] symbol;
   logic       last;
   logic [1:0] status;

   modport source (output valid, output symbol, output last, output status, input ready);
   modport sink   (input valid, input symbol, input last, input status, output ready);
endinterface

// ----- design/rne_front.sv -----
`timescale 1ns / 1ps

module rne_front
   import rne_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rne_req_if.sink       req,
   output logic          push_valid,
   output rne_entry_type push_entry,
   input  logic          push_ready
);

   // stage 1: status, thousands digit, remainder < 1000
   logic           s1_valid_ff, s1_valid_in;
   rne_status_type s1_status_ff, s1_status_in;
   logic [2:0]     s1_th_ff, s1_th_in;
   logic [9:0]     s1_rem_ff, s1_rem_in;

   // stage 2: hundreds digit, remainder < 100
   logic           s2_valid_ff, s2_valid_in;
   rne_status_type s2_status_ff;
   logic [2:0]     s2_th_ff;
   rne_digit_type  s2_h_ff, s2_h_in;
   logic [6:0]     s2_rem_ff, s2_rem_in;

   logic        en1, en2;
   logic [11:0] v12;
   logic [24:0] prod1;
   logic [15:0] prod2;
   logic [13:0] prod3;
   rne_digit_type tens, ones;

   assign en2       = !s2_valid_ff || push_ready;
   assign en1       = !s1_valid_ff || en2;
   assign req.ready = en1;

   // stage 1 datapath
   always_comb begin
      v12   = req.value[11:0];
      prod1 = 25'(v12) * 25'(RECIP_THOUSAND);
      s1_th_in  = prod1[24:22];
      s1_rem_in = 10'(v12 - 12'(12'(s1_th_in) * 12'd1000));
      if (req.value == 16'd0) begin
         s1_status_in = STATUS_ZERO;
      end else if (req.value > MAX_VALUE) begin
         s1_status_in = STATUS_OVER;
      end else begin
         s1_status_in = STATUS_OK;
      end
      s1_valid_in = en1 ? req.valid : s1_valid_ff;
   end

   // stage 2 datapath
   always_comb begin
      prod2     = 16'(s1_rem_ff) * 16'(RECIP_HUNDRED);
      s2_h_in   = prod2[15:12];
      s2_rem_in = 7'(s1_rem_ff - 10'(10'(s2_h_in) * 10'd100));
      s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   end

   // last split happens on the way into the queue
   always_comb begin
      prod3 = 14'(s2_rem_ff) * 14'(RECIP_TEN);
      tens  = prod3[13:10];
      ones  = 4'(s2_rem_ff - 7'(7'(tens) * 7'd10));
      push_entry.status    = s2_status_ff;
      push_entry.digits[3] = {1'b0, s2_th_ff};
      push_entry.digits[2] = s2_h_ff;
      push_entry.digits[1] = tens;
      push_entry.digits[0] = ones;
      push_entry.start     = 2'd0;
      for (int j = 0; j < NUM_POS; j++) begin
         if (push_entry.digits[j] != 4'd0) begin
            push_entry.start = 2'(j);
         end
      end
   end

   assign push_valid = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_status_ff <= s1_status_in;
         s1_th_ff     <= s1_th_in;
         s1_rem_ff    <= s1_rem_in;
      end
      if (en2) begin
         s2_status_ff <= s1_status_ff;
         s2_th_ff     <= s1_th_ff;
         s2_h_ff      <= s2_h_in;
         s2_rem_ff    <= s2_rem_in;
      end
   end

endmodule

// ----- design/rne_queue.sv -----
`timescale 1ns / 1ps

module rne_queue
   import rne_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  rne_entry_type push_entry,
   output logic          push_ready,
   output logic          head_valid,
   output rne_entry_type head_entry,
   input  logic          pop
);

   rne_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/rne_back.sv -----
`timescale 1ns / 1ps
`include "roman_numeral_encoder_top_macros.svh"

module rne_back
   import rne_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  rne_entry_type head_entry,
   output logic          pop,
   rne_rsp_if.source     rsp
);

   // cursor into the head entry; fresh means "start at head.start, step 0"
   logic          fresh_ff, fresh_in;
   rne_pos_type   pos_ff, pos_in;
   logic [1:0]    step_ff, step_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_symbol_ff;
   logic                rsp_last_ff;
   rne_status_type      rsp_status_ff;

   rne_pos_type         cur_pos, next_pos;
   logic [1:0]          cur_step;
   rne_digit_type       cur_digit;
   logic                special, digit_end, has_lower, last_now, out_en, fire;
   logic [SYMBOL_W-1:0] sym_now;

   always_comb begin
      cur_pos   = fresh_ff ? head_entry.start : pos_ff;
      cur_step  = fresh_ff ? 2'd0 : step_ff;
      cur_digit = head_entry.digits[cur_pos];
      special   = (head_entry.status != STATUS_OK);
      digit_end = (3'({1'b0, cur_step}) + 3'd1 == digit_len(cur_digit));

      has_lower = 1'b0;
      next_pos  = 2'd0;
      for (int j = 0; j < NUM_POS; j++) begin
         if (2'(j) < cur_pos && head_entry.digits[j] != 4'd0) begin
            has_lower = 1'b1;
            next_pos  = 2'(j);
         end
      end

      last_now = special || (digit_end && !has_lower);
      sym_now  = special ? SYM_NONE : digit_symbol(cur_digit, cur_pos, cur_step);

      out_en = !rsp_valid_ff || rsp.ready;
      fire   = head_valid && out_en;
      pop    = fire && last_now;

      fresh_in = fresh_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      if (fire) begin
         fresh_in = last_now;
         if (digit_end) begin
            pos_in  = next_pos;
            step_in = 2'd0;
         end else begin
            pos_in  = cur_pos;
            step_in = cur_step + 2'd1;
         end
      end

      rsp_valid_in = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b1;
         pos_ff       <= 2'd0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_symbol_ff <= sym_now;
         rsp_last_ff   <= last_now;
         rsp_status_ff <= head_entry.status;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.symbol = rsp_symbol_ff;
   assign rsp.last   = rsp_last_ff;
   assign rsp.status = rsp_status_ff;

   `RNE_ASSERT_NOW(a_flag_result_empty, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK), (rsp_symbol_ff == SYM_NONE) && rsp_last_ff, "flagged result must be empty and last")
   `RNE_ASSERT_NOW(a_ok_has_symbol, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_OK), rsp_symbol_ff != SYM_NONE, "ok result without symbol")
   `RNE_ASSERT_NOW(a_flag_starts_fresh, clock, reset, fire && special, fresh_ff, "flagged item seen mid-run")
   `RNE_ASSERT_NEXT(a_last_rearms, clock, reset, fire && last_now, fresh_ff, "cursor not rearmed after last symbol")
   `RNE_ASSERT_NEXT(a_mid_run_holds, clock, reset, fire && !last_now, !fresh_ff, "cursor rearmed before last symbol")

endmodule

// ----- design/roman_numeral_encoder_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// req_bus   in   valid / ready    value[15:0]
// rsp_bus   out  valid / ready    symbol[6:0], last, status[1:0]
//
// One result per cycle while rsp_bus is ready and an item waits, from the single
// back-end sequencer: one per numeral symbol (1 to 15), one empty if out of range.
// An accepted item passes two split stages, the queue and the output register.
// Reset is synchronous and active high; no clearing pass, intake resumes next cycle.
// A stalled result holds the output register; the two-entry queue and front
// stages keep accepting until full, then req_bus.ready drops.

module roman_numeral_encoder_top
   import rne_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rne_req_if.sink   req_bus,
   rne_rsp_if.source rsp_bus
);

   // front -> queue
   logic          push_valid;
   logic          push_ready;
   rne_entry_type push_entry;

   // queue -> back
   logic          head_valid;
   rne_entry_type head_entry;
   logic          pop;

   // front: checks range, splits the value into decimal digits over two
   // registered stages (reciprocal multiplies), finds the leading digit
   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // two-entry queue decouples digit split from symbol output
   rne_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // back: walks the head entry digit by digit, one symbol per cycle while the output register can take it,
   // pops it with the last symbol so the next item follows without a gap
   rne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

// ----- dv/roman_numeral_encoder_checker.sv -----
`timescale 1ns / 1ps

module roman_numeral_encoder_checker
   import rne_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rne_req_if   req_mon,
   rne_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      rne_status_type      status;
   } numeral_char_type;

   // decimal place -> weight, unit and five symbols
   localparam int PLACE_WEIGHT [4] = '{1, 10, 100, 1000};
   localparam logic [SYMBOL_W-1:0] UNIT_CHAR [4] = '{SYM_I, SYM_X, SYM_C, SYM_M};
   localparam logic [SYMBOL_W-1:0] FIVE_CHAR [4] = '{SYM_V, SYM_L, SYM_D, SYM_NONE};

   numeral_char_type numeral_q [$];
   int               error_tally = 0;

   function automatic void flag_error(input string msg);
      error_tally++;
      if (error_tally <= 10)
         $display("[%0t] numeral error: %s", $time, msg);
   endfunction

   // expands one value into the symbols it should produce
   function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
      logic [SYMBOL_W-1:0] chars [16];
      int                  n;
      int                  d;
      numeral_char_type    e;
      n = 0;
      if (v == '0 || v > MAX_VALUE) begin
         e.symbol = SYM_NONE;
         e.last   = 1'b1;
         e.status = (v == '0) ? STATUS_ZERO : STATUS_OVER;
         numeral_q.insert(numeral_q.size(), e);
         return;
      end
      for (int p = 3; p >= 0; p--) begin
         d = (int'(v) / PLACE_WEIGHT[p]) % 10;
         if (d == 4 || d == 9) begin
            chars[n]     = UNIT_CHAR[p];
            chars[n + 1] = (d == 4) ? FIVE_CHAR[p] : UNIT_CHAR[p + 1];
            n += 2;
         end else begin
            if (d >= 5) begin
               chars[n] = FIVE_CHAR[p];
               n++;
            end
            for (int k = 0; k < d % 5; k++) begin
               chars[n] = UNIT_CHAR[p];
               n++;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         e.symbol = chars[k];
         e.last   = (k == n - 1);
         e.status = STATUS_OK;
         numeral_q.insert(numeral_q.size(), e);
      end
   endfunction

   always @(posedge clock) begin
      numeral_char_type want;
      if (reset) begin
         numeral_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (numeral_q.size() == 0) begin
               flag_error($sformatf("unexpected item: sym %h last %b status %0d",
                                    rsp_mon.symbol, rsp_mon.last, rsp_mon.status));
            end else begin
               want = numeral_q.pop_front();
               if (rsp_mon.symbol !== want.symbol || rsp_mon.last !== want.last ||
                   rsp_mon.status !== want.status)
                  flag_error($sformatf(
                     "expected sym %h last %b status %0d, got sym %h last %b status %0d",
                     want.symbol, want.last, want.status,
                     rsp_mon.symbol, rsp_mon.last, rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_numeral(req_mon.value);
      end
      pending_count  <= numeral_q.size();
      mismatch_count <= error_tally;
   end

endmodule

// ----- dv/roman_numeral_encoder_top_test.sv -----
`timescale 1ns / 1ps

module roman_numeral_encoder_top_test;
   import rne_pkg::*;

   localparam int RANDOM_ITEMS = 300;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int HOLD_CYCLES  = 200;   // one long receiver hold-off
   localparam int HOLD_AFTER   = 300;   // results taken before that hold-off
   localparam int DRAIN_CYCLES = 12;    // extra wait after the scoreboard empties

   // zero, over-range, all-ones, the longest numeral, each subtractive form
   // (4, 9, 40, 90, 400, 900), digit ranges 1..3 and 5..8, top of range
   localparam logic [VALUE_W-1:0] CORNER_VALUES [22] = '{
      16'd0, 16'd1, 16'd4, 16'd5, 16'd8, 16'd9, 16'd40, 16'd90, 16'd400,
      16'd900, 16'd1000, 16'd3000, 16'd3888, 16'd3999, 16'd4000, 16'd65535,
      16'd444, 16'd999, 16'd1994, 16'd2768, 16'd32768, 16'd3549
   };

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   quiet_cycles = 0;
   bit   req_burst = 1'b0;

   rne_req_if req_bus ();
   rne_rsp_if rsp_bus ();

   roman_numeral_encoder_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scoreboard sits beside the block, watching both channels
   roman_numeral_encoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one item after a random gap; returns on the edge it is taken.
   // Burst stretches drop the gap to zero so valid stays high back to back.
   task automatic send_value(input logic [VALUE_W-1:0] v);
      int gap;
      if ($urandom_range(0, 29) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // stimulus and verdict
   initial begin
      int                 pick;
      logic [VALUE_W-1:0] v;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNER_VALUES[i])
         send_value(CORNER_VALUES[i]);

      // mostly convertible values, some zero / over-range / raw 16-bit noise
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            v = VALUE_W'($urandom_range(1, 3999));
         else if (pick < 80)
            v = VALUE_W'($urandom_range(1, 99));
         else if (pick < 88)
            v = VALUE_W'($urandom_range(4000, 65535));
         else if (pick < 93)
            v = '0;
         else
            v = VALUE_W'($urandom);
         send_value(v);
      end
      req_bus.valid <= 1'b0;

      // pending_count is registered and trails the scoreboard; let the last prediction land first
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Result side: random stall before each item, burst stretches with ready
   // held high, and one long hold-off so the queue fills and req ready drops.
   initial begin
      int stall;
      int taken;
      bit rsp_burst;
      taken     = 0;
      rsp_burst = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 10);
         if (taken == HOLD_AFTER)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
      end
   end

   // watchdog: too long with nothing moving means the block hung
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
